[rtl/aes_pkg.sv]
// ----------------------------------------------------------------------------
// AES-128 package
// Shared constants, types, S-box tables and round functions.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int ROUNDS     = 10;
	localparam int KEY_WORDS  = 4;
	localparam int RK_DEPTH   = 4 * (ROUNDS + 1);
	localparam int RK_AW      = $clog2(RK_DEPTH);
	localparam int RND_W      = $clog2(ROUNDS + 1);

	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;
	localparam logic MODE_ENC     = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} core_state_t;

	typedef enum logic [1:0] {
		KX_IDLE,
		KX_RUN
	} kx_state_t;

	typedef struct packed {
		logic        busy;
		logic [RK_AW-1:0] addr;
	} kx_status_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
		return t[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	// state byte i = column i/4, row i%4
	function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		int c, r, src;
		o = '0;
		for (c = 0; c < 4; c++) begin
			for (r = 0; r < 4; r++) begin
				if (inv) begin
					src = ((c - r + 4) % 4) * 4 + r;
					o[127 - 8*(c*4+r) -: 8] = inv_sbox(byte_of(s, src));
				end else begin
					src = ((c + r) % 4) * 4 + r;
					o[127 - 8*(c*4+r) -: 8] = sbox(byte_of(s, src));
				end
			end
		end
		return o;
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] a, input logic inv);
		logic [7:0] b [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m0, m1, m2, m3;
		int i;
		for (i = 0; i < 4; i++) begin
			b[i]  = a[31 - 8*i -: 8];
			x2[i] = xtime(b[i]);
			x4[i] = xtime(x2[i]);
			x8[i] = xtime(x4[i]);
		end
		if (!inv) begin
			m0 = x2[0] ^ x2[1] ^ b[1] ^ b[2] ^ b[3];
			m1 = b[0] ^ x2[1] ^ x2[2] ^ b[2] ^ b[3];
			m2 = b[0] ^ b[1] ^ x2[2] ^ x2[3] ^ b[3];
			m3 = x2[0] ^ b[0] ^ b[1] ^ b[2] ^ x2[3];
		end else begin
			// e=8^4^2, b=8^2^1, d=8^4^1, 9=8^1
			m0 = (x8[0]^x4[0]^x2[0]) ^ (x8[1]^x2[1]^b[1]) ^ (x8[2]^x4[2]^b[2]) ^ (x8[3]^b[3]);
			m1 = (x8[0]^b[0]) ^ (x8[1]^x4[1]^x2[1]) ^ (x8[2]^x2[2]^b[2]) ^ (x8[3]^x4[3]^b[3]);
			m2 = (x8[0]^x4[0]^b[0]) ^ (x8[1]^b[1]) ^ (x8[2]^x4[2]^x2[2]) ^ (x8[3]^x2[3]^b[3]);
			m3 = (x8[0]^x2[0]^b[0]) ^ (x8[1]^x4[1]^b[1]) ^ (x8[2]^b[2]) ^ (x8[3]^x4[3]^x2[3]);
		end
		return {m0, m1, m2, m3};
	endfunction

	function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		int c;
		o = '0;
		for (c = 0; c < 4; c++)
			o[127 - 32*c -: 32] = mix_col(s[127 - 32*c -: 32], inv);
		return o;
	endfunction

endpackage

[rtl/aes128_block_cipher.sv]
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Encrypts or decrypts one 128-bit block per beat using stored round keys.
// ----------------------------------------------------------------------------
// Write key_high (index 0) and key_low (index 1) through the config port;
// each write re-expands the key into the round-key RAM, finished once all
// 44 words are written. Wait that long before sending a beat.
// The input channel takes mode and a block when in_valid is high and
// in_stall is low. in_stall stays high while a block is in work and until
// its result is taken. Each of the 11 key additions reads the four
// round-key words through the single RAM read port, one at a time, and
// then applies the shared round unit. out_valid rises after the last
// key addition, and no new input beat is taken until the result is
// taken. The result sits on out_valid until a cycle with out_stall low.
// A stalled result holds its value. Reset clears the sequencers; the key
// registers go to zero and the RAM is undefined until a key is written.
// ----------------------------------------------------------------------------
module aes128_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);
	logic [63:0] key_high_q, key_low_q;
	logic        kx_start_q;
	aes_pkg::kx_status_t kx_st;
	logic [31:0] kx_wdata, rk_rdata;
	logic [aes_pkg::RK_AW-1:0] rk_addr;
	logic [127:0] res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			kx_start_q <= 1'b0;
		end else begin
			kx_start_q <= cfg_we;
			if (cfg_we && cfg_index == aes_pkg::REG_KEY_HIGH) key_high_q <= cfg_data;
			if (cfg_we && cfg_index == aes_pkg::REG_KEY_LOW)  key_low_q  <= cfg_data;
		end
	end

	aes_key_expand u_kx (
		.clk(clk), .arst_n(arst_n), .start(kx_start_q),
		.key({key_high_q, key_low_q}), .status(kx_st), .wdata(kx_wdata)
	);

	aes_ram #(.WIDTH(32), .DEPTH(aes_pkg::RK_DEPTH)) u_ram (
		.clk(clk), .we(kx_st.busy), .waddr(kx_st.addr), .wdata(kx_wdata),
		.raddr(rk_addr), .rdata(rk_rdata)
	);

	aes_round_core u_core (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .blk({block_high, block_low}), .out_valid(out_valid),
		.out_stall(out_stall), .res(res), .rk_addr(rk_addr), .rk(rk_rdata)
	);

	assign result_high = res[127:64];
	assign result_low  = res[63:0];
endmodule

[rtl/aes_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 44
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/aes_key_expand.sv]
// ----------------------------------------------------------------------------
// AES-128 key expansion
// Writes the 44 round-key words, one word per cycle, after a key write.
// ----------------------------------------------------------------------------
module aes_key_expand (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [127:0]              key,
	output aes_pkg::kx_status_t       status,
	output logic [31:0]               wdata
);
	aes_pkg::kx_state_t state_q, state_d;
	logic [aes_pkg::RK_AW-1:0] idx_q;
	logic [127:0] win_q;
	logic [7:0]   rc_q;
	logic [31:0]  t, nw;
	logic         last;

	assign last = (idx_q == aes_pkg::RK_AW'(aes_pkg::RK_DEPTH - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			aes_pkg::KX_IDLE: if (start) state_d = aes_pkg::KX_RUN;
			aes_pkg::KX_RUN:  if (last && !start) state_d = aes_pkg::KX_IDLE;
			default: state_d = aes_pkg::KX_IDLE;
		endcase
	end

	always_comb begin
		t = win_q[31:0];
		if (idx_q[1:0] == 2'd0) begin
			t = {aes_pkg::sbox(t[23:16]), aes_pkg::sbox(t[15:8]),
			     aes_pkg::sbox(t[7:0]), aes_pkg::sbox(t[31:24])} ^ {rc_q, 24'h0};
		end
		nw = (idx_q < aes_pkg::RK_AW'(aes_pkg::KEY_WORDS)) ? win_q[127 - 32*idx_q[1:0] -: 32]
		                                                    : win_q[127:96] ^ t;
	end

	assign wdata  = nw;
	assign status = '{busy: (state_q == aes_pkg::KX_RUN), addr: idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::KX_IDLE;
			idx_q   <= '0;
			rc_q    <= 8'h01;
		end else begin
			state_q <= state_d;
			if (start) begin
				idx_q <= '0;
				rc_q  <= 8'h01;
			end else if (state_q == aes_pkg::KX_RUN) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q >= aes_pkg::RK_AW'(aes_pkg::KEY_WORDS) && idx_q[1:0] == 2'd0) begin
					rc_q <= aes_pkg::xtime(rc_q);
				end
			end
		end
	end

	// window holds words i-4..i-1 once past the key words
	always_ff @(posedge clk) begin
		if (start) begin
			win_q <= key;
		end else if (state_q == aes_pkg::KX_RUN && idx_q >= aes_pkg::RK_AW'(3)) begin
			win_q <= (idx_q == aes_pkg::RK_AW'(3)) ? win_q : {win_q[95:0], nw};
		end
	end
endmodule

[rtl/aes_round_core.sv]
// ----------------------------------------------------------------------------
// AES-128 round core
// One shared round unit stepped by a small sequencer that fetches each round key before applying its round.
// ----------------------------------------------------------------------------
module aes_round_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic [127:0]               blk,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [127:0]               res,
	output logic [aes_pkg::RK_AW-1:0]  rk_addr,
	input  logic [31:0]                rk
);
	aes_pkg::core_state_t state_q, state_d;
	logic [aes_pkg::RND_W-1:0] rnd_q, rnd_d, step_rnd;
	logic [1:0]   col_q;
	logic         load_q;
	logic [127:0] st_q, sr, rnd_out;
	logic         inv_q, in_acc, fetch, last_round;
	logic [31:0]  rk_word_q [3];
	logic [127:0] rk_full;

	assign in_acc = in_valid && !in_stall;

	// fetch four words of a round key, then apply the round
	assign fetch      = (state_q == aes_pkg::ST_RUN);
	assign last_round = inv_q ? (rnd_q == '0)
	                          : (rnd_q == aes_pkg::RND_W'(aes_pkg::ROUNDS));
	assign step_rnd   = inv_q ? rnd_q - 1'b1 : rnd_q + 1'b1;
	assign rk_addr    = {rnd_q, 2'b00} + aes_pkg::RK_AW'(col_q);
	assign rk_full    = {rk_word_q[0], rk_word_q[1], rk_word_q[2], rk};

	always_comb begin
		sr = aes_pkg::sub_shift(st_q, inv_q);
		if (inv_q) begin
			if (rnd_q == aes_pkg::RND_W'(aes_pkg::ROUNDS)) rnd_out = st_q ^ rk_full;
			else if (rnd_q == '0)                         rnd_out = sr ^ rk_full;
			else                                          rnd_out = aes_pkg::mix(sr ^ rk_full, 1'b1);
		end else begin
			if (rnd_q == '0)                                    rnd_out = st_q ^ rk_full;
			else if (rnd_q == aes_pkg::RND_W'(aes_pkg::ROUNDS)) rnd_out = sr ^ rk_full;
			else                                                rnd_out = aes_pkg::mix(sr, 1'b0) ^ rk_full;
		end
	end

	always_comb begin
		state_d = state_q;
		rnd_d   = rnd_q;
		case (state_q)
			aes_pkg::ST_IDLE: if (in_acc) state_d = aes_pkg::ST_RUN;
			aes_pkg::ST_RUN:  if (load_q && last_round) state_d = aes_pkg::ST_DONE;
			aes_pkg::ST_DONE: if (!out_stall) state_d = aes_pkg::ST_IDLE;
			default: state_d = aes_pkg::ST_IDLE;
		endcase
		if (in_acc) rnd_d = (mode == aes_pkg::MODE_ENC) ? '0 : aes_pkg::RND_W'(aes_pkg::ROUNDS);
		else if (load_q && !last_round) rnd_d = step_rnd;
	end

	assign in_stall  = (state_q != aes_pkg::ST_IDLE);
	assign out_valid = (state_q == aes_pkg::ST_DONE);
	assign res       = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::ST_IDLE;
			rnd_q   <= '0;
			col_q   <= '0;
			load_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
			load_q  <= fetch && (col_q == 2'd3) && !load_q;
			if (in_acc || load_q) col_q <= '0;
			else if (fetch && !(col_q == 2'd3)) col_q <= col_q + 1'b1;
		end
	end

	logic [1:0] col_s1;
	logic       fv_s1;
	always_ff @(posedge clk) begin
		col_s1 <= col_q;
		fv_s1  <= fetch && !load_q;
		if (fv_s1 && col_s1 != 2'd3) rk_word_q[col_s1] <= rk;
		if (in_acc) begin
			st_q  <= blk;
			inv_q <= mode;
		end else if (load_q) begin
			st_q <= rnd_out;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("accepted input while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(res)))
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		load_q |-> (state_q == aes_pkg::ST_RUN))
		else $error("round applied outside run");
endmodule
